// ===== rtl/fcs_pkg.sv =====
package fcs_pkg;

  // Transaction kinds on the input channel
  typedef enum logic [1:0] {
    REQ_TICK  = 2'd0,
    REQ_START = 2'd1,
    REQ_EVAL  = 2'd2,
    REQ_OFF   = 2'd3
  } req_type_t;

  // Sequence steps, also reported on the phase output
  typedef enum logic [1:0] {
    STEP_IDLE   = 2'd0,
    STEP_ISSUE  = 2'd1,
    STEP_SETTLE = 2'd2,
    STEP_GRADE  = 2'd3
  } step_t;

  // Event codes on the result channel
  typedef enum logic [1:0] {
    EV_NONE    = 2'd0,
    EV_REACHED = 2'd1,
    EV_OFF     = 2'd2
  } event_t;

  // Configuration register indexes (byte address = 4 * index)
  typedef enum logic [1:0] {
    REG_REACH_TIMEOUT = 2'd0,
    REG_SETTLE_TIME   = 2'd1,
    REG_BAND_NARROW   = 2'd2,
    REG_BAND_WIDE     = 2'd3
  } reg_idx_t;

  localparam int unsigned SP_W    = 13;
  localparam int unsigned MEAS_W  = 14;
  localparam int unsigned DRIVE_W = 14;
  localparam int unsigned CNT_W   = 16;
  localparam int unsigned BAND_W  = 11;
  localparam int unsigned ERR_W   = 14;
  localparam int unsigned PROD_W  = SP_W + BAND_W;   // 24-bit band compare
  localparam int unsigned Q_SHIFT = 10;              // Q10 fractions
  localparam int unsigned ADDR_W  = 4;
  localparam int unsigned DATA_W  = 32;

  localparam logic [DRIVE_W-1:0] DRIVE_OFFSET = 14'd8192;
  localparam logic [CNT_W-1:0]   COUNT_MAX    = 16'hFFFF;

  localparam logic [CNT_W-1:0]  RST_REACH_TIMEOUT = 16'd10;
  localparam logic [CNT_W-1:0]  RST_SETTLE_TIME   = 16'd3;
  localparam logic [BAND_W-1:0] RST_BAND_NARROW   = 11'd102;
  localparam logic [BAND_W-1:0] RST_BAND_WIDE     = 11'd512;

endpackage

// ===== rtl/flow_controller_supervisor.sv =====
// Flow controller supervisor for one mass-flow controller channel.
// Input channel (in_valid/in_stall): one transaction carries req_type
// (tick, start, evaluate, off), setpoint, measured flow and valve_select.
// Result channel (out_valid/out_stall): exactly one result per input
// transaction, in order: drive value, both valve drives, reached flag,
// three fault flags, event code and the sequence phase after the item.
// out_valid rises when an accepted item moves from the input register into
// the result register. The input register forms |error| and the two band
// products, the second stage compares and updates the sequence state
// together with the result register. Throughput is one transaction per
// cycle; a new item is taken every cycle while the result side keeps up.
// When the receiver stalls, the result register holds and the input register
// keeps one more item, after which in_stall rises until the result is taken.
// Configuration goes through the APB-style cfg_ port (4 registers at byte
// addresses 0, 4, 8, 12); the user must write it only while the block is
// idle, which the block does not enforce. Reset (synchronous, rst_n low)
// returns the sequence to idle, closes both valves, clears flags and
// counters, parks the drive at 8192 and loads the register defaults.
module flow_controller_supervisor (
  input  logic                           clk,
  input  logic                           rst_n,
  // input channel
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [1:0]                     in_req_type,
  input  logic [fcs_pkg::SP_W-1:0]       in_setpoint,
  input  logic signed [fcs_pkg::MEAS_W-1:0] in_measured,
  input  logic                           in_valve_select,
  // result channel
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [fcs_pkg::DRIVE_W-1:0]    out_drive_value,
  output logic                           out_valve_zero_open,
  output logic                           out_valve_one_open,
  output logic                           out_reached,
  output logic                           out_fault_no_reach,
  output logic                           out_fault_big_error,
  output logic                           out_fault_no_control,
  output logic [1:0]                     out_event_code,
  output logic [1:0]                     out_phase,
  // configuration port
  input  logic                           cfg_psel,
  input  logic                           cfg_penable,
  input  logic                           cfg_pwrite,
  input  logic [fcs_pkg::ADDR_W-1:0]     cfg_paddr,
  input  logic [fcs_pkg::DATA_W-1:0]     cfg_pwdata,
  output logic [fcs_pkg::DATA_W-1:0]     cfg_prdata,
  output logic                           cfg_pready
);

  // ---------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------
  logic [fcs_pkg::CNT_W-1:0]  reach_timeout_r;
  logic [fcs_pkg::CNT_W-1:0]  settle_time_r;
  logic [fcs_pkg::BAND_W-1:0] band_narrow_r;
  logic [fcs_pkg::BAND_W-1:0] band_wide_r;
  logic                       cfg_wr;
  fcs_pkg::reg_idx_t          cfg_idx;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite;
  assign cfg_idx    = fcs_pkg::reg_idx_t'(cfg_paddr[3:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      reach_timeout_r <= fcs_pkg::RST_REACH_TIMEOUT;
      settle_time_r   <= fcs_pkg::RST_SETTLE_TIME;
      band_narrow_r   <= fcs_pkg::RST_BAND_NARROW;
      band_wide_r     <= fcs_pkg::RST_BAND_WIDE;
    end else if (cfg_wr) begin
      case (cfg_idx)
        fcs_pkg::REG_REACH_TIMEOUT: reach_timeout_r <= cfg_pwdata[fcs_pkg::CNT_W-1:0];
        fcs_pkg::REG_SETTLE_TIME:   settle_time_r   <= cfg_pwdata[fcs_pkg::CNT_W-1:0];
        fcs_pkg::REG_BAND_NARROW:   band_narrow_r   <= cfg_pwdata[fcs_pkg::BAND_W-1:0];
        fcs_pkg::REG_BAND_WIDE:     band_wide_r     <= cfg_pwdata[fcs_pkg::BAND_W-1:0];
        default: ;
      endcase
    end
  end

  // register read-back
  always_comb begin
    case (cfg_idx)
      fcs_pkg::REG_REACH_TIMEOUT:
        cfg_prdata = {{(fcs_pkg::DATA_W-fcs_pkg::CNT_W){1'b0}}, reach_timeout_r};
      fcs_pkg::REG_SETTLE_TIME:
        cfg_prdata = {{(fcs_pkg::DATA_W-fcs_pkg::CNT_W){1'b0}}, settle_time_r};
      fcs_pkg::REG_BAND_NARROW:
        cfg_prdata = {{(fcs_pkg::DATA_W-fcs_pkg::BAND_W){1'b0}}, band_narrow_r};
      fcs_pkg::REG_BAND_WIDE:
        cfg_prdata = {{(fcs_pkg::DATA_W-fcs_pkg::BAND_W){1'b0}}, band_wide_r};
      default:
        cfg_prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------
  // Pipeline control
  // ---------------------------------------------------------------
  logic s1_vld_r;
  logic out_vld_r;
  logic adv;       // result register can take a new value
  logic in_take;
  logic s2_fire;

  assign adv      = ~out_vld_r | ~out_stall;
  assign in_stall = s1_vld_r & ~adv;
  assign in_take  = in_valid & ~in_stall;
  assign s2_fire  = s1_vld_r & adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      if (~s1_vld_r | adv) s1_vld_r <= in_valid;
      if (adv) out_vld_r <= s1_vld_r;
    end
  end

  assign out_valid = out_vld_r;

  // ---------------------------------------------------------------
  // Stage 1: input register with |error| and the band limits
  // ---------------------------------------------------------------
  fcs_pkg::req_type_t                s1_req_r;
  logic [fcs_pkg::DRIVE_W-1:0]       s1_target_r;
  logic                              s1_vsel_r;
  logic [fcs_pkg::ERR_W-1:0]         s1_err_r;
  logic [fcs_pkg::PROD_W-1:0]        s1_lim_n_r;
  logic [fcs_pkg::PROD_W-1:0]        s1_lim_w_r;

  logic signed [fcs_pkg::MEAS_W:0]   diff;
  logic [fcs_pkg::MEAS_W:0]          diff_abs;
  logic [fcs_pkg::PROD_W-1:0]        lim_n;
  logic [fcs_pkg::PROD_W-1:0]        lim_w;

  // measured - setpoint fits 15 bits signed; its magnitude fits 14 bits
  assign diff     = $signed({in_measured[fcs_pkg::MEAS_W-1], in_measured})
                  - $signed({2'b00, in_setpoint});
  assign diff_abs = diff[fcs_pkg::MEAS_W] ? 15'(-diff) : 15'(diff);
  assign lim_n    = fcs_pkg::PROD_W'(in_setpoint) * fcs_pkg::PROD_W'(band_narrow_r);
  assign lim_w    = fcs_pkg::PROD_W'(in_setpoint) * fcs_pkg::PROD_W'(band_wide_r);

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_req_r    <= fcs_pkg::req_type_t'(in_req_type);
      s1_target_r <= {1'b0, in_setpoint} + fcs_pkg::DRIVE_OFFSET;
      s1_vsel_r   <= in_valve_select;
      s1_err_r    <= diff_abs[fcs_pkg::ERR_W-1:0];
      s1_lim_n_r  <= lim_n;
      s1_lim_w_r  <= lim_w;
    end
  end

  // ---------------------------------------------------------------
  // Stage 2: compare and sequence update
  // ---------------------------------------------------------------
  fcs_pkg::step_t               step_r, step_nxt;
  logic [fcs_pkg::DRIVE_W-1:0]  drive_r, drive_nxt;
  logic [fcs_pkg::CNT_W-1:0]    reach_cnt_r, reach_cnt_nxt;
  logic [fcs_pkg::CNT_W-1:0]    settle_cnt_r, settle_cnt_nxt;
  logic                         reached_r, reached_nxt;
  logic                         no_reach_r, no_reach_nxt;
  logic                         big_err_r, big_err_nxt;
  logic                         no_ctrl_r, no_ctrl_nxt;
  logic                         valve0_r, valve0_nxt;
  logic                         valve1_r, valve1_nxt;
  fcs_pkg::event_t              event_r, event_nxt;

  logic [fcs_pkg::PROD_W-1:0]   err_s;
  logic                         drive_match;
  logic                         in_narrow;
  logic                         below_wide;
  logic                         settle_done;

  assign err_s       = {s1_err_r, {fcs_pkg::Q_SHIFT{1'b0}}};
  assign drive_match = (drive_r == s1_target_r);
  assign in_narrow   = (err_s <= s1_lim_n_r);
  assign below_wide  = (err_s < s1_lim_w_r);
  assign settle_done = drive_match & in_narrow & (settle_cnt_r > settle_time_r);

  // sequence next state
  always_comb begin
    step_nxt = step_r;
    case (s1_req_r)
      fcs_pkg::REQ_START: step_nxt = fcs_pkg::STEP_ISSUE;
      fcs_pkg::REQ_OFF:   step_nxt = fcs_pkg::STEP_IDLE;
      fcs_pkg::REQ_EVAL: begin
        case (step_r)
          fcs_pkg::STEP_ISSUE:  step_nxt = fcs_pkg::STEP_SETTLE;
          fcs_pkg::STEP_SETTLE: if (settle_done) step_nxt = fcs_pkg::STEP_GRADE;
          default: ;
        endcase
      end
      default: ;
    endcase
  end

  // drive, valves, counters, flags and event
  always_comb begin
    drive_nxt      = drive_r;
    reach_cnt_nxt  = reach_cnt_r;
    settle_cnt_nxt = settle_cnt_r;
    reached_nxt    = reached_r;
    no_reach_nxt   = no_reach_r;
    big_err_nxt    = big_err_r;
    no_ctrl_nxt    = no_ctrl_r;
    valve0_nxt     = valve0_r;
    valve1_nxt     = valve1_r;
    event_nxt      = fcs_pkg::EV_NONE;
    case (s1_req_r)
      fcs_pkg::REQ_TICK: begin
        if (reach_cnt_r != fcs_pkg::COUNT_MAX) reach_cnt_nxt = reach_cnt_r + 1'b1;
        if (settle_cnt_r != fcs_pkg::COUNT_MAX) settle_cnt_nxt = settle_cnt_r + 1'b1;
      end
      fcs_pkg::REQ_OFF: begin
        drive_nxt      = fcs_pkg::DRIVE_OFFSET;
        reach_cnt_nxt  = '0;
        settle_cnt_nxt = '0;
        reached_nxt    = 1'b0;
        no_reach_nxt   = 1'b0;
        big_err_nxt    = 1'b0;
        no_ctrl_nxt    = 1'b0;
        valve0_nxt     = 1'b0;
        valve1_nxt     = 1'b0;
        event_nxt      = fcs_pkg::EV_OFF;
      end
      fcs_pkg::REQ_EVAL: begin
        case (step_r)
          fcs_pkg::STEP_ISSUE: begin
            drive_nxt      = s1_target_r;
            valve0_nxt     = ~s1_vsel_r;
            valve1_nxt     = s1_vsel_r;
            reached_nxt    = 1'b0;
            no_reach_nxt   = 1'b0;
            big_err_nxt    = 1'b0;
            no_ctrl_nxt    = 1'b0;
            reach_cnt_nxt  = '0;
            settle_cnt_nxt = '0;
          end
          fcs_pkg::STEP_SETTLE: begin
            if (!drive_match) begin
              drive_nxt = s1_target_r;
            end else if (in_narrow) begin
              if (settle_done) begin
                no_reach_nxt = 1'b0;
                reached_nxt  = 1'b1;
                event_nxt    = fcs_pkg::EV_REACHED;
              end
            end else begin
              settle_cnt_nxt = '0;
              if (reach_cnt_r > reach_timeout_r) no_reach_nxt = 1'b1;
            end
          end
          fcs_pkg::STEP_GRADE: begin
            if (!drive_match) begin
              drive_nxt = s1_target_r;
            end else if (!in_narrow) begin
              big_err_nxt = below_wide;
              no_ctrl_nxt = ~below_wide;
            end else begin
              big_err_nxt = 1'b0;
              no_ctrl_nxt = 1'b0;
            end
          end
          default: ;
        endcase
      end
      default: ;
    endcase
  end

  // state and result registers advance together when the result moves
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r       <= fcs_pkg::STEP_IDLE;
      drive_r      <= fcs_pkg::DRIVE_OFFSET;
      reach_cnt_r  <= '0;
      settle_cnt_r <= '0;
      reached_r    <= 1'b0;
      no_reach_r   <= 1'b0;
      big_err_r    <= 1'b0;
      no_ctrl_r    <= 1'b0;
      valve0_r     <= 1'b0;
      valve1_r     <= 1'b0;
      event_r      <= fcs_pkg::EV_NONE;
    end else if (s2_fire) begin
      step_r       <= step_nxt;
      drive_r      <= drive_nxt;
      reach_cnt_r  <= reach_cnt_nxt;
      settle_cnt_r <= settle_cnt_nxt;
      reached_r    <= reached_nxt;
      no_reach_r   <= no_reach_nxt;
      big_err_r    <= big_err_nxt;
      no_ctrl_r    <= no_ctrl_nxt;
      valve0_r     <= valve0_nxt;
      valve1_r     <= valve1_nxt;
      event_r      <= event_nxt;
    end
  end

  // result fields come straight from the state registers
  assign out_drive_value      = drive_r;
  assign out_valve_zero_open  = valve0_r;
  assign out_valve_one_open   = valve1_r;
  assign out_reached          = reached_r;
  assign out_fault_no_reach   = no_reach_r;
  assign out_fault_big_error  = big_err_r;
  assign out_fault_no_control = no_ctrl_r;
  assign out_event_code       = event_r;
  assign out_phase            = step_r;

endmodule

// ===== rtl/fcs_checker.sv =====
module fcs_checker (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         out_valid,
  input logic                         out_stall,
  input logic [fcs_pkg::DRIVE_W-1:0]  out_drive_value,
  input logic                         out_valve_zero_open,
  input logic                         out_valve_one_open,
  input logic                         out_reached,
  input logic                         out_fault_big_error,
  input logic                         out_fault_no_control,
  input logic [1:0]                   out_event_code,
  input logic [1:0]                   out_phase
);

  // a stalled result transaction holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_drive_value)
      && $stable(out_event_code) && $stable(out_phase))
    else $error("result changed while stalled");

  // off leaves the channel parked: idle, valves shut, drive at offset
  a_off_parks: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_event_code == fcs_pkg::EV_OFF |->
      out_phase == fcs_pkg::STEP_IDLE && !out_valve_zero_open && !out_valve_one_open
      && !out_reached && out_drive_value == fcs_pkg::DRIVE_OFFSET)
    else $error("off did not park the channel");

  // the reached event comes with the flag and the grading step
  a_reach_event: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_event_code == fcs_pkg::EV_REACHED |->
      out_reached && out_phase == fcs_pkg::STEP_GRADE)
    else $error("reached event without reached state");

  // at most one valve open
  a_one_valve: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_valve_zero_open && out_valve_one_open))
    else $error("both valves open");

  // the two error grades exclude each other
  a_grade_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_fault_big_error && out_fault_no_control))
    else $error("big error and no control both set");

endmodule

bind flow_controller_supervisor fcs_checker u_fcs_checker (
  .clk                  (clk),
  .rst_n                (rst_n),
  .out_valid            (out_valid),
  .out_stall            (out_stall),
  .out_drive_value      (out_drive_value),
  .out_valve_zero_open  (out_valve_zero_open),
  .out_valve_one_open   (out_valve_one_open),
  .out_reached          (out_reached),
  .out_fault_big_error  (out_fault_big_error),
  .out_fault_no_control (out_fault_no_control),
  .out_event_code       (out_event_code),
  .out_phase            (out_phase)
);
